[rtl/rotation_matrix_to_euler_unit_defines.svh]
// Assertion macros for the rotation matrix to Euler angle unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ROTATION_MATRIX_TO_EULER_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RME_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rme assertion failed");

// Checks that the consequent holds after the antecedent, delayed by the lat argument.
`define RME_ASSERT_DELAY(name, ante, lat, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
        else $error("rme assertion failed");

`endif

[rtl/rme_pkg.sv]
// Shared types, constants and helper functions of the rotation matrix to Euler unit.
// Depends on nothing; every RTL module imports it.
`timescale 1ns / 1ps
`default_nettype none

package rme_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int TABLE_LEN = 24;
    localparam int SQRT_STEPS = 29;
    // Input register, two root chains, mid and prep registers, CORDIC chain, output register.
    localparam int LATENCY = 2 * SQRT_STEPS + CORDIC_STAGES + 4;

    localparam logic signed [31:0] PI_Z = 32'sd843314857;
    localparam logic signed [33:0] PI_ANG = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI_ANG = 34'sd421657428;

    typedef enum logic [1:0] {
        OP_XYZ = 2'd0,
        OP_YZX = 2'd1,
        OP_ZXY = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] m_00;
        logic signed [15:0] m_01;
        logic signed [15:0] m_02;
        logic signed [15:0] m_10;
        logic signed [15:0] m_11;
        logic signed [15:0] m_12;
        logic signed [15:0] m_20;
        logic signed [15:0] m_21;
        logic signed [15:0] m_22;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               gimbal_lock;
    } result_t;

    typedef struct packed {
        logic [57:0] v;
        logic [30:0] rem;
        logic [28:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
        logic               zero;
    } lane_t;

    typedef struct packed {
        logic               valid;
        logic               bad_op;
        logic               lock;
        logic               lock_neg;
        logic               dneg;
        axis_t              slot_p;
        axis_t              slot_s;
        axis_t              slot_t;
        logic signed [15:0] p;
        logic signed [15:0] e;
        logic signed [15:0] ta;
        logic signed [15:0] tb;
        logic signed [15:0] la;
        logic signed [15:0] lb;
        logic [31:0]        pp;
        logic [31:0]        ee;
        logic [57:0]        vq;
        logic [28:0]        c;
        sq_t                sq;
        lane_t [2:0]        lane;
    } work_t;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] r;
        begin
            case (idx)
                5'd0:    r = 32'sd210828714;
                5'd1:    r = 32'sd124459457;
                5'd2:    r = 32'sd65760959;
                5'd3:    r = 32'sd33381290;
                5'd4:    r = 32'sd16755422;
                5'd5:    r = 32'sd8385879;
                5'd6:    r = 32'sd4193963;
                5'd7:    r = 32'sd2097109;
                5'd8:    r = 32'sd1048571;
                5'd9:    r = 32'sd524287;
                5'd10:   r = 32'sd262144;
                5'd11:   r = 32'sd131072;
                5'd12:   r = 32'sd65536;
                5'd13:   r = 32'sd32768;
                5'd14:   r = 32'sd16384;
                5'd15:   r = 32'sd8192;
                5'd16:   r = 32'sd4096;
                5'd17:   r = 32'sd2048;
                5'd18:   r = 32'sd1024;
                5'd19:   r = 32'sd512;
                5'd20:   r = 32'sd256;
                5'd21:   r = 32'sd128;
                5'd22:   r = 32'sd64;
                5'd23:   r = 32'sd32;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    // Element in Q1.14 scaled to the Q28 length format.
    function automatic logic signed [33:0] scale14(input logic signed [15:0] v);
        return {{4{v[15]}}, v, 14'b0};
    endfunction

    // Folds a vector into the right half plane before the CORDIC rotations.
    function automatic lane_t lane_prep(input logic signed [33:0] y,
                                        input logic signed [33:0] x);
        lane_t l;
        begin
            l.zero = (x == 34'sd0) && (y == 34'sd0);
            if (x < 34'sd0) begin
                l.z = (y >= 34'sd0) ? PI_Z : -PI_Z;
                l.x = -x;
                l.y = -y;
            end
            else begin
                l.z = 32'sd0;
                l.x = x;
                l.y = y;
            end
            return l;
        end
    endfunction

    // Q28 angle to Q3.12, rounding half toward plus infinity.
    function automatic logic signed [15:0] to_q12(input logic signed [33:0] v);
        logic signed [33:0] t;
        begin
            t = v + 34'sd32768;
            return t[31:16];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/rme_sqrt_cell.sv]
// One cell of the integer square root chain: settles one root bit per cell.
// Depends on rme_pkg for the pipeline word type.
`timescale 1ns / 1ps
`default_nettype none

module rme_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  rme_pkg::work_t din,
    output rme_pkg::work_t dout
);
    import rme_pkg::*;

    work_t       work_reg;
    work_t       work_next;
    logic [32:0] rem_ext;
    logic [32:0] trial;

    always_comb
    begin
        work_next = din;
        rem_ext = {din.sq.rem, din.sq.v[57:56]};
        trial = {2'b00, din.sq.root, 2'b01};
        work_next.sq.v = {din.sq.v[55:0], 2'b00};
        if (rem_ext >= trial)
        begin
            work_next.sq.rem = 31'(rem_ext - trial);
            work_next.sq.root = {din.sq.root[27:0], 1'b1};
        end
        else
        begin
            work_next.sq.rem = rem_ext[30:0];
            work_next.sq.root = {din.sq.root[27:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
        end
        else
        begin
            work_reg <= work_next;
        end
    end

    assign dout = work_reg;

endmodule

`default_nettype wire

[rtl/rme_cordic_cell.sv]
// One vectoring CORDIC cell, applied to the three angle lanes of a pipeline word.
// Depends on rme_pkg for the word type and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module rme_cordic_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [4:0]     stage,
    input  rme_pkg::work_t din,
    output rme_pkg::work_t dout
);
    import rme_pkg::*;

    work_t              work_reg;
    work_t              work_next;
    logic signed [33:0] dx [3];
    logic signed [33:0] dy [3];
    logic signed [31:0] step_angle;

    always_comb
    begin
        work_next = din;
        step_angle = atan_entry(stage);
        for (int l = 0; l < 3; l++)
        begin
            dx[l] = din.lane[l].x >>> stage;
            dy[l] = din.lane[l].y >>> stage;
            // Rotate toward the x axis; a zero y takes the counterclockwise branch.
            if (din.lane[l].y > 34'sd0)
            begin
                work_next.lane[l].x = din.lane[l].x + dy[l];
                work_next.lane[l].y = din.lane[l].y - dx[l];
                work_next.lane[l].z = din.lane[l].z + step_angle;
            end
            else
            begin
                work_next.lane[l].x = din.lane[l].x - dy[l];
                work_next.lane[l].y = din.lane[l].y + dx[l];
                work_next.lane[l].z = din.lane[l].z - step_angle;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
        end
        else
        begin
            work_reg <= work_next;
        end
    end

    assign dout = work_reg;

endmodule

`default_nettype wire

[rtl/rotation_matrix_to_euler_unit.sv]
// Top level of the rotation matrix to Euler angle unit.
// Depends on rme_pkg, rme_sqrt_cell, rme_cordic_cell and the assertion macro header.
//
// Usage:
// A command transfer happens at a rising edge with start high; busy is always
// low, so a new matrix may be issued in every cycle. cmd carries the rotation
// order and the nine Q1.14 elements.
// Each result appears on result for exactly one cycle with done high; on its way
// it passes two 29-cell square root chains, 14 CORDIC cells and four registers
// for selection, the mid step, lane setup and the output.
// Throughput is one matrix per cycle; results leave in command order.
// The receiver cannot stall: it must take each result in its done cycle.
// The user writes the lock threshold on the cfg channel (cfg_ready is always high)
// only while no command is in flight; the block does not enforce this.
// Reset clears the pipeline (not the result register), so items in flight are
// dropped, and sets the lock threshold to 2.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_euler_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rme_pkg::cmd_t    cmd,
    output logic             done,
    output rme_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [10:0]      cfg_data
);
    import rme_pkg::*;

    `include "rotation_matrix_to_euler_unit_defines.svh"

    logic [10:0]        thr_reg;
    work_t              a_reg;
    work_t              a_next;
    work_t              m_reg;
    work_t              m_next;
    work_t              p_reg;
    work_t              p_next;
    work_t              b_work;
    work_t              s1 [SQRT_STEPS + 1];
    work_t              s2 [SQRT_STEPS + 1];
    work_t              s3 [CORDIC_STAGES + 1];
    work_t              fw;
    logic               done_reg;
    result_t            result_reg;
    result_t            result_next;
    logic               bad_op_now;

    logic signed [31:0] pprod;
    logic signed [31:0] eprod;
    logic signed [17:0] p_ext;
    logic signed [17:0] thr_s;
    logic [31:0]        q;
    logic signed [30:0] e28;
    logic signed [30:0] c_s;
    logic               lock2;
    logic signed [33:0] av [3];
    logic signed [33:0] ang [3];
    logic signed [33:0] pivot_ang;
    logic signed [33:0] sec_ang;
    logic signed [33:0] third_ang;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 11'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Input step: pick the elements for the rotation order and test the pivot.
    always_comb
    begin
        a_next = '0;
        a_next.valid = start && !busy;
        case (cmd.operation)
            OP_XYZ:
            begin
                a_next.p = cmd.m_02;
                a_next.e = cmd.m_12;
                a_next.dneg = cmd.m_22[15];
                a_next.ta = cmd.m_01;
                a_next.tb = cmd.m_00;
                a_next.la = cmd.m_10;
                a_next.lb = cmd.m_11;
                a_next.slot_p = AXIS_Y;
                a_next.slot_s = AXIS_X;
                a_next.slot_t = AXIS_Z;
                a_next.lock_neg = 1'b1;
            end
            OP_YZX:
            begin
                a_next.p = cmd.m_10;
                a_next.e = cmd.m_20;
                a_next.dneg = cmd.m_00[15];
                a_next.ta = cmd.m_12;
                a_next.tb = cmd.m_11;
                a_next.la = cmd.m_21;
                a_next.lb = cmd.m_22;
                a_next.slot_p = AXIS_Z;
                a_next.slot_s = AXIS_Y;
                a_next.slot_t = AXIS_X;
                a_next.lock_neg = 1'b1;
            end
            OP_ZXY:
            begin
                a_next.p = cmd.m_21;
                a_next.e = cmd.m_01;
                a_next.dneg = cmd.m_11[15];
                a_next.ta = cmd.m_20;
                a_next.tb = cmd.m_22;
                a_next.la = cmd.m_02;
                a_next.lb = cmd.m_00;
                a_next.slot_p = AXIS_X;
                a_next.slot_s = AXIS_Z;
                a_next.slot_t = AXIS_Y;
                a_next.lock_neg = 1'b0;
            end
            default:
            begin
                a_next.bad_op = 1'b1;
            end
        endcase
        pprod = a_next.p * a_next.p;
        eprod = a_next.e * a_next.e;
        a_next.pp = pprod;
        a_next.ee = eprod;
        p_ext = 18'(a_next.p);
        thr_s = $signed({7'b0, thr_reg});
        a_next.lock = (p_ext > (18'sd16384 - thr_s)) || (p_ext < (thr_s - 18'sd16384));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
        end
    end

    // The first root takes (1 - p^2) in Q56 and yields cos of the pivot angle in Q28.
    always_comb
    begin
        b_work = a_reg;
        q = 32'h1000_0000 - a_reg.pp;
        b_work.vq = {q[29:0], 28'b0};
        b_work.sq.v = {q[29:0], 28'b0};
        b_work.sq.rem = '0;
        b_work.sq.root = '0;
    end

    assign s1[0] = b_work;

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt1
        rme_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (s1[g]),
            .dout (s1[g + 1])
        );
    end

    // Mid step: c^2 equals the radicand minus the root remainder, so the
    // second radicand c^2 - e^2 needs no wide multiplier.
    always_comb
    begin
        m_next = s1[SQRT_STEPS];
        m_next.c = s1[SQRT_STEPS].sq.root;
        e28 = {s1[SQRT_STEPS].e[15], s1[SQRT_STEPS].e, 14'b0};
        c_s = $signed({2'b00, s1[SQRT_STEPS].sq.root});
        lock2 = (s1[SQRT_STEPS].sq.root == 29'd0) || (e28 > c_s) || (-e28 > c_s);
        m_next.lock = s1[SQRT_STEPS].lock || lock2;
        m_next.sq.v = s1[SQRT_STEPS].vq - 58'(s1[SQRT_STEPS].sq.rem)
                      - {s1[SQRT_STEPS].ee[29:0], 28'b0};
        m_next.sq.rem = '0;
        m_next.sq.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else
        begin
            m_reg <= m_next;
        end
    end

    assign s2[0] = m_reg;

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt2
        rme_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (s2[g]),
            .dout (s2[g + 1])
        );
    end

    // Lane setup: pivot, second angle and third (or lock) angle vectors.
    always_comb
    begin
        p_next = s2[SQRT_STEPS];
        p_next.lane[0] = lane_prep(scale14(s2[SQRT_STEPS].p),
                                   {5'b0, s2[SQRT_STEPS].c});
        p_next.lane[1] = lane_prep(scale14(s2[SQRT_STEPS].e),
                                   {5'b0, s2[SQRT_STEPS].sq.root});
        if (s2[SQRT_STEPS].lock)
        begin
            p_next.lane[2] = lane_prep(-scale14(s2[SQRT_STEPS].la),
                                       scale14(s2[SQRT_STEPS].lb));
        end
        else
        begin
            p_next.lane[2] = lane_prep(scale14(s2[SQRT_STEPS].ta),
                                       scale14(s2[SQRT_STEPS].tb));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else
        begin
            p_reg <= p_next;
        end
    end

    assign s3[0] = p_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        rme_cordic_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .stage(5'(g)),
            .din  (s3[g]),
            .dout (s3[g + 1])
        );
    end

    assign fw = s3[CORDIC_STAGES];

    // Output step: place the three angles on their axes, or zero the result for an unused order.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            av[l] = fw.lane[l].zero ? 34'sd0 : 34'(fw.lane[l].z);
        end
        if (fw.lock)
        begin
            pivot_ang = fw.p[15] ? HALF_PI_ANG : -HALF_PI_ANG;
            sec_ang = 34'sd0;
            third_ang = fw.lock_neg ? -av[2] : av[2];
        end
        else
        begin
            pivot_ang = -av[0];
            sec_ang = fw.dneg ? (PI_ANG - av[1]) : av[1];
            third_ang = av[2];
        end
        for (int k = 0; k < 3; k++)
        begin
            if (fw.slot_p == axis_t'(2'(k)))
            begin
                ang[k] = pivot_ang;
            end
            else if (fw.slot_s == axis_t'(2'(k)))
            begin
                ang[k] = sec_ang;
            end
            else
            begin
                ang[k] = third_ang;
            end
        end
        if (fw.bad_op)
        begin
            result_next = '0;
        end
        else
        begin
            result_next.angle_x = to_q12(ang[0]);
            result_next.angle_y = to_q12(ang[1]);
            result_next.angle_z = to_q12(ang[2]);
            result_next.gimbal_lock = fw.lock;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

    assign bad_op_now = start && !busy && (cmd.operation == OP_UNUSED);

    `RME_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)
    `RME_ASSERT_IMPLY(a_no_orphan, done, $past(start && !busy, LATENCY))
    `RME_ASSERT_IMPLY(a_bad_op_clear, done && $past(bad_op_now, LATENCY), result == '0)

endmodule

`default_nettype wire

[test/rotation_matrix_to_euler_unit_tb.sv]
// Testbench for rotation_matrix_to_euler_unit: random and directed matrices with
// an in-bench fixed-point predictor of the Euler angles and the gimbal-lock flag.
// Depends on rme_pkg and the rotation_matrix_to_euler_unit RTL.
`timescale 1ns / 1ps

module rotation_matrix_to_euler_unit_tb;
    import rme_pkg::*;

    localparam longint ONE_Q14 = 16384;
    localparam longint ONE_SQ_Q28 = 268435456;
    localparam longint PI_Q28 = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam int CFG_LOCK_THRESHOLD = 0;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    cmd_t        pending_cmds[$];
    result_t     expected_angles[$];
    int          lock_thr;
    int          sender_idle_pct;
    int          error_count;

    rotation_matrix_to_euler_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        end
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        begin
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                z = (y >= 0) ? PI_Q28 : -PI_Q28;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++)
            begin
                dx = x >>> i;
                dy = y >>> i;
                if (y > 0)
                begin
                    x = x + dy;
                    y = y - dx;
                    z = z + longint'(atan_entry(i[4:0]));
                end
                else
                begin
                    x = x - dy;
                    y = y + dx;
                    z = z - longint'(atan_entry(i[4:0]));
                end
            end
            return z;
        end
    endfunction

    function automatic logic signed [15:0] rad_q12(input longint v);
        longint t;
        begin
            t = (v + 32768) >>> 16;
            return t[15:0];
        end
    endfunction

    function automatic result_t predict_angles(input cmd_t c, input int thr);
        longint m[9];
        longint ang[3];
        longint p, e, c28, e28, s28, sec, a;
        longint unsigned d;
        int ip, ie, id, ta, tb, la, lb, sp, ss, st, lsign;
        logic lock;
        result_t r;
        begin
            m[0] = c.m_00; m[1] = c.m_01; m[2] = c.m_02;
            m[3] = c.m_10; m[4] = c.m_11; m[5] = c.m_12;
            m[6] = c.m_20; m[7] = c.m_21; m[8] = c.m_22;
            ang[0] = 0; ang[1] = 0; ang[2] = 0;
            c28 = 0;
            e28 = 0;
            r = '0;
            case (c.operation)
                OP_XYZ:
                begin
                    ip = 2; ie = 5; id = 8; ta = 1; tb = 0; la = 3; lb = 4;
                    sp = AXIS_Y; ss = AXIS_X; st = AXIS_Z; lsign = -1;
                end
                OP_YZX:
                begin
                    ip = 3; ie = 6; id = 0; ta = 5; tb = 4; la = 7; lb = 8;
                    sp = AXIS_Z; ss = AXIS_Y; st = AXIS_X; lsign = -1;
                end
                OP_ZXY:
                begin
                    ip = 7; ie = 1; id = 4; ta = 6; tb = 8; la = 2; lb = 0;
                    sp = AXIS_X; ss = AXIS_Z; st = AXIS_Y; lsign = 1;
                end
                default:
                    return r;
            endcase
            p = m[ip];
            e = m[ie];
            lock = (p > ONE_Q14 - thr) || (p < -ONE_Q14 + thr);
            if (!lock)
            begin
                c28 = longint'(int_sqrt(longint'(ONE_SQ_Q28 - p * p) << 28));
                e28 = e * ONE_Q14;
                if (c28 == 0 || e28 > c28 || -e28 > c28)
                    lock = 1'b1;
            end
            if (lock)
            begin
                a = vector_angle(-m[la] * ONE_Q14, m[lb] * ONE_Q14);
                ang[sp] = (p < 0) ? HALF_PI_Q28 : -HALF_PI_Q28;
                ang[ss] = 0;
                ang[st] = (lsign < 0) ? -a : a;
            end
            else
            begin
                d = longint'(c28 * c28) - longint'(e28 * e28);
                s28 = longint'(int_sqrt(d));
                sec = vector_angle(e28, s28);
                if (m[id] < 0)
                    sec = PI_Q28 - sec;
                ang[sp] = -vector_angle(p * ONE_Q14, c28);
                ang[ss] = sec;
                ang[st] = vector_angle(m[ta] * ONE_Q14, m[tb] * ONE_Q14);
            end
            r.angle_x = rad_q12(ang[0]);
            r.angle_y = rad_q12(ang[1]);
            r.angle_z = rad_q12(ang[2]);
            r.gimbal_lock = lock;
            return r;
        end
    endfunction

    function automatic logic signed [15:0] to_elem(input real v);
        return 16'($rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)));
    endfunction

    function automatic real rand_angle();
        return $urandom_range(0, 62831) / 10000.0 - 3.14159;
    endfunction

    // Mostly true rotations, some pushed close to the lock boundary, some raw noise.
    function automatic cmd_t random_matrix();
        cmd_t c;
        real a, b, g, sa, ca, sb, cb, sg, cg;
        int kind;
        logic signed [15:0] near;
        logic [159:0] raw;
        begin
            c.operation = $urandom_range(0, 15) == 0 ? OP_UNUSED : 2'($urandom_range(0, 2));
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                c = raw[$bits(cmd_t) - 1:0];
                return c;
            end
            a = rand_angle();
            b = rand_angle();
            g = rand_angle();
            sa = $sin(a); ca = $cos(a);
            sb = $sin(b); cb = $cos(b);
            sg = $sin(g); cg = $cos(g);
            c.m_00 = to_elem(cb * cg);
            c.m_01 = to_elem(sa * sb * cg - ca * sg);
            c.m_02 = to_elem(ca * sb * cg + sa * sg);
            c.m_10 = to_elem(cb * sg);
            c.m_11 = to_elem(sa * sb * sg + ca * cg);
            c.m_12 = to_elem(ca * sb * sg - sa * cg);
            c.m_20 = to_elem(-sb);
            c.m_21 = to_elem(sa * cb);
            c.m_22 = to_elem(ca * cb);
            if (kind < 40)
            begin
                near = 16'(16384 - $urandom_range(0, 1100));
                if ($urandom_range(0, 1))
                    near = -near;
                case (c.operation)
                    OP_XYZ: c.m_02 = near;
                    OP_YZX: c.m_10 = near;
                    default: c.m_21 = near;
                endcase
            end
            return c;
        end
    endfunction

    function automatic cmd_t make_cmd(input int op, input int v0, input int v1,
                                      input int v2, input int v3, input int v4,
                                      input int v5, input int v6, input int v7,
                                      input int v8);
        return '{2'(op), 16'(v0), 16'(v1), 16'(v2), 16'(v3), 16'(v4), 16'(v5),
                 16'(v6), 16'(v7), 16'(v8)};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver: a command transfer happens at an edge with start high and busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_angles.push_back(predict_angles(cmd, lock_thr));
                void'(pending_cmds.pop_front());
            end
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                cmd <= pending_cmds[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every done cycle carries one result transfer.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_angles.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_angles.pop_front();
                if (result.angle_x !== want.angle_x)
                    report_mismatch("angle_x", int'(result.angle_x), int'(want.angle_x));
                if (result.angle_y !== want.angle_y)
                    report_mismatch("angle_y", int'(result.angle_y), int'(want.angle_y));
                if (result.angle_z !== want.angle_z)
                    report_mismatch("angle_z", int'(result.angle_z), int'(want.angle_z));
                if (result.gimbal_lock !== want.gimbal_lock)
                    report_mismatch("gimbal_lock", int'(result.gimbal_lock),
                                    int'(want.gimbal_lock));
            end
        end
    end

    task automatic write_threshold(input int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= 11'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        lock_thr = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_angles.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        int thresholds[5];
        int idle_pcts[5];
        thresholds = '{0, 1024, 2047, 37, 2};
        idle_pcts = '{19, 46, 0, 19, 0};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        lock_thr = 2;
        sender_idle_pct = 0;
        error_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity per order, unused order, pivot at one, minus one and just below one, zero matrix.
        for (int op = 0; op < 4; op++)
            pending_cmds.push_back(make_cmd(op, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_cmds.push_back(make_cmd(OP_XYZ, 0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        pending_cmds.push_back(make_cmd(OP_YZX, 0, 0, 0, -16384, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ZXY, 0, 0, 0, 0, 0, 0, 0, 16383, 0));
        pending_cmds.push_back(make_cmd(OP_XYZ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Extremes of the element range, pivot out of range.
        pending_cmds.push_back(make_cmd(OP_XYZ, 32767, -32768, 32767, -32768, 32767,
                                        -32768, 32767, -32768, 32767));
        pending_cmds.push_back(make_cmd(OP_ZXY, -32768, 32767, -32768, 32767, -32768,
                                        32767, -32768, 32767, -32768));
        // Second argument beyond one, and negative mirror diagonal.
        pending_cmds.push_back(make_cmd(OP_XYZ, 8000, 0, 8192, 0, 0, 16000, 0, 0, -100));
        pending_cmds.push_back(make_cmd(OP_YZX, -16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        pending_cmds.push_back(make_cmd(OP_ZXY, 16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        // Third atan2 with a zero on the negative axis and a zero vector.
        pending_cmds.push_back(make_cmd(OP_XYZ, -16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        pending_cmds.push_back(make_cmd(OP_YZX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Lock answers for each order.
        pending_cmds.push_back(make_cmd(OP_XYZ, 0, 0, -16384, -16384, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_YZX, 0, 0, 0, 16384, 0, 0, 0, 16384, 0));
        pending_cmds.push_back(make_cmd(OP_ZXY, 0, 0, -16384, 0, 0, 0, 0, -16383, 0));
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(thresholds[ph]);
            sender_idle_pct = idle_pcts[ph];
            for (int i = 0; i < 210; i++)
                pending_cmds.push_back(random_matrix());
            drain();
        end

        if (error_count == 0)
            $display("rotation_matrix_to_euler_unit: match");
        else
            $display("rotation_matrix_to_euler_unit: mismatch");
        $finish;
    end

    initial
    begin
        #(20 * 400000);
        $display("rotation_matrix_to_euler_unit: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rme_pkg.sv
rtl/rme_sqrt_cell.sv
rtl/rme_cordic_cell.sv
rtl/rotation_matrix_to_euler_unit.sv
test/rotation_matrix_to_euler_unit_tb.sv
